[hw/rtl/wsch_pkg.sv]
// package for the weekly time window scheduler
// holds field widths, register indexes, mode, event and target codes, and the
// config and state types; no dependencies
package wsch_pkg;

    localparam int unsigned SEC_W   = 17;
    localparam int unsigned DAY_W   = 3;
    localparam int unsigned MASK_W  = 7;
    localparam int unsigned WIN_W   = 8;
    localparam int unsigned MODE_W  = 2;
    localparam int unsigned EV_W    = 2;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned CFG_W   = 17;
    localparam int unsigned IN_TW   = 24;
    localparam int unsigned OUT_TW  = 8;

    // one divide step per remainder bit
    localparam int unsigned DIV_STEPS = SEC_W;
    localparam int unsigned CNT_W     = 5;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [IDX_W-1:0] REG_DAY_MASK = 3'd1;
    localparam logic [IDX_W-1:0] REG_START    = 3'd2;
    localparam logic [IDX_W-1:0] REG_END      = 3'd3;
    localparam logic [IDX_W-1:0] REG_DURATION = 3'd4;
    localparam logic [IDX_W-1:0] REG_REPEAT   = 3'd5;
    localparam logic [IDX_W-1:0] REG_ONE_SHOT = 3'd6;

    // schedule modes
    localparam logic [MODE_W-1:0] MODE_WINDOW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ONE_SHOT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REPEAT   = 2'd2;

    // event codes
    localparam logic [EV_W-1:0] EV_NONE = 2'd0;
    localparam logic [EV_W-1:0] EV_RISE = 2'd1;
    localparam logic [EV_W-1:0] EV_FALL = 2'd2;

    // weekday used for yesterday of sunday and of the invalid day seven
    localparam logic [DAY_W-1:0] DAY_SAT = 3'd6;
    localparam logic [DAY_W-1:0] DAY_SUN = 3'd0;
    localparam logic [DAY_W-1:0] DAY_BAD = 3'd7;

    typedef enum logic [1:0] {
        TGT_OFF,
        TGT_ON,
        TGT_NONE
    } t_tgt;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] day_mask;
        logic [SEC_W-1:0]  start_second;
        logic [SEC_W-1:0]  end_second;
        logic [SEC_W-1:0]  duration_seconds;
        logic [SEC_W-1:0]  repeat_seconds;
        logic [WIN_W-1:0]  one_shot_window;
    } t_cfg;

endpackage

[hw/rtl/weekly_time_window_scheduler.sv]
// weekly time window scheduler top level: config registers, sequencer,
// level state and output register; depends on wsch_pkg, wsch_rem, wsch_target
//
// usage:
//   the input stream carries one tick per beat: second of day and weekday.
//   every tick gives exactly one result beat with the new level and an event
//   code (none, became active, became inactive).
//   registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, one per
//   cycle; the user must do so only while no tick is in flight (the block
//   does not enforce this); index seven is ignored.
// operation:
//   a tick passes the 17-step remainder unit, one bit of the period remainder
//   per cycle, then a decide step that loads the output register.
//   s_axis_tready is high only while the sequencer is idle, so a new tick is
//   taken only once the previous one has left the decide step.
//   a finished result waits in the output register; if the receiver stalls,
//   the next tick is still accepted and worked on, and the block holds it in
//   the decide step until the output register frees.
// reset:
//   synchronous, active low; the level goes inactive, registers take their
//   reset values, no result is pending.
module weekly_time_window_scheduler (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config write port
    input  logic                        i_cfg_we,
    input  logic [wsch_pkg::IDX_W-1:0]  i_cfg_idx,
    input  logic [wsch_pkg::CFG_W-1:0]  i_cfg_data,
    // tick input
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [wsch_pkg::IN_TW-1:0]  s_axis_tdata,   // [16:0] second_of_day, [19:17] weekday
    // result output
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [wsch_pkg::OUT_TW-1:0] m_axis_tdata    // [0] active_level, [2:1] event_code
);
    import wsch_pkg::*;

    t_cfg             r_cfg, n_cfg;
    t_state           r_state, n_state;
    logic [SEC_W-1:0] r_now;
    logic [DAY_W-1:0] r_wd;
    logic             r_neg;
    logic             r_flag, n_flag;
    logic             r_m_valid, n_m_valid;
    logic             r_m_level, n_m_level;
    logic [EV_W-1:0]  r_m_ev, n_m_ev;

    logic             accept;
    logic             emit;
    logic [SEC_W:0]   diff;
    logic [SEC_W-1:0] abs_diff;
    logic             div_last;
    logic [SEC_W-1:0] rem;
    t_tgt             target;

    assign accept = s_axis_tvalid && s_axis_tready;

    // signed offset from the start time, magnitude to the remainder unit
    always_comb begin
        diff     = {1'b0, s_axis_tdata[SEC_W-1:0]} - {1'b0, r_cfg.start_second};
        abs_diff = diff[SEC_W] ? SEC_W'(-diff) : diff[SEC_W-1:0];
    end

    wsch_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (abs_diff),
        .i_divisor  (r_cfg.repeat_seconds),
        .o_last     (div_last),
        .o_rem      (rem)
    );

    wsch_target u_target (
        .i_cfg      (r_cfg),
        .i_now      (r_now),
        .i_weekday  (r_wd),
        .i_diff_neg (r_neg),
        .i_rem      (rem),
        .o_target   (target)
    );

    // config register writes
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:     n_cfg.mode             = i_cfg_data[MODE_W-1:0];
                REG_DAY_MASK: n_cfg.day_mask         = i_cfg_data[MASK_W-1:0];
                REG_START:    n_cfg.start_second     = i_cfg_data[SEC_W-1:0];
                REG_END:      n_cfg.end_second       = i_cfg_data[SEC_W-1:0];
                REG_DURATION: n_cfg.duration_seconds = i_cfg_data[SEC_W-1:0];
                REG_REPEAT:   n_cfg.repeat_seconds   = i_cfg_data[SEC_W-1:0];
                REG_ONE_SHOT: n_cfg.one_shot_window  = i_cfg_data[WIN_W-1:0];
                default:      n_cfg = r_cfg;
            endcase
        end
    end

    // sequencer, level update and output register
    always_comb begin
        n_state       = r_state;
        n_flag        = r_flag;
        n_m_valid     = r_m_valid && !m_axis_tready;
        n_m_level     = r_m_level;
        n_m_ev        = r_m_ev;
        s_axis_tready = (r_state == ST_IDLE);
        emit          = (r_state == ST_EMIT) && (!r_m_valid || m_axis_tready);
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (div_last) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (emit) begin
                    n_state   = ST_IDLE;
                    n_m_valid = 1'b1;
                    n_m_ev    = EV_NONE;
                    if (target == TGT_ON && !r_flag) begin
                        n_flag = 1'b1;
                        n_m_ev = EV_RISE;
                    end else if (target == TGT_OFF && r_flag) begin
                        n_flag = 1'b0;
                        n_m_ev = EV_FALL;
                    end
                    n_m_level = n_flag;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state                  <= ST_IDLE;
            r_flag                   <= 1'b0;
            r_m_valid                <= 1'b0;
            r_cfg.mode               <= MODE_WINDOW;
            r_cfg.day_mask           <= '0;
            r_cfg.start_second       <= '0;
            r_cfg.end_second         <= '0;
            r_cfg.duration_seconds   <= '0;
            r_cfg.repeat_seconds     <= SEC_W'(1);
            r_cfg.one_shot_window    <= WIN_W'(2);
        end else begin
            r_state   <= n_state;
            r_flag    <= n_flag;
            r_m_valid <= n_m_valid;
            r_cfg     <= n_cfg;
        end
        r_m_level <= n_m_level;
        r_m_ev    <= n_m_ev;
    end

    // tick capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= s_axis_tdata[SEC_W-1:0];
            r_wd  <= s_axis_tdata[SEC_W +: DAY_W];
            r_neg <= diff[SEC_W];
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(OUT_TW-1-EV_W){1'b0}}, r_m_ev, r_m_level};

endmodule

[hw/rtl/wsch_rem.sv]
// iterative remainder unit: one restoring subtract step per cycle
// depends on wsch_pkg
module wsch_rem (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wsch_pkg::SEC_W-1:0] i_dividend,
    input  logic [wsch_pkg::SEC_W-1:0] i_divisor,
    output logic                      o_last,
    output logic [wsch_pkg::SEC_W-1:0] o_rem
);
    import wsch_pkg::*;

    logic             r_busy, n_busy;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [SEC_W-1:0] r_rem, n_rem;
    logic [SEC_W-1:0] r_dvd, n_dvd;
    logic [SEC_W-1:0] r_dvs, n_dvs;
    logic [SEC_W:0]   trial;
    logic [SEC_W:0]   diff;

    // shared shift, compare and subtract
    always_comb begin
        trial  = {r_rem, r_dvd[SEC_W-1]};
        diff   = trial - {1'b0, r_dvs};
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIV_STEPS);
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = diff[SEC_W] ? trial[SEC_W-1:0] : diff[SEC_W-1:0];
            n_dvd = {r_dvd[SEC_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_last = r_busy && (r_cnt == CNT_W'(1));
    assign o_rem  = r_rem;

endmodule

[hw/rtl/wsch_target.sv]
// target level decision for all three modes
// depends on wsch_pkg; the repeat mode uses the remainder from wsch_rem
module wsch_target (
    input  wsch_pkg::t_cfg             i_cfg,
    input  logic [wsch_pkg::SEC_W-1:0] i_now,
    input  logic [wsch_pkg::DAY_W-1:0] i_weekday,
    input  logic                       i_diff_neg,
    input  logic [wsch_pkg::SEC_W-1:0] i_rem,
    output wsch_pkg::t_tgt             o_target
);
    import wsch_pkg::*;

    logic [MASK_W:0]  mask8;
    logic [DAY_W-1:0] yd;
    logic             today;
    logic             yesterday;
    logic [SEC_W:0]   os_stop;
    logic [SEC_W-1:0] s;
    logic [SEC_W-1:0] e;
    logic [SEC_W-1:0] now;
    t_tgt             win_tgt;

    // day bits, the invalid day seven never has a bit
    always_comb begin
        mask8     = {1'b0, i_cfg.day_mask};
        yd        = (i_weekday == DAY_SUN || i_weekday == DAY_BAD) ? DAY_SAT
                                                                   : i_weekday - 1'b1;
        today     = mask8[i_weekday];
        yesterday = mask8[yd];
    end

    // start/stop window, later tests override earlier ones
    always_comb begin
        s       = i_cfg.start_second;
        e       = i_cfg.end_second;
        now     = i_now;
        win_tgt = TGT_NONE;
        if (e >= s) begin
            if (today) begin
                if (s > now && e >= now) win_tgt = TGT_OFF;
                if (s <= now && e > now) win_tgt = TGT_ON;
                if (s <= now && e < now) win_tgt = TGT_OFF;
            end
        end else begin
            if (yesterday) begin
                if (s >= now && e > now) win_tgt = TGT_ON;
                if (s >= now && e < now) win_tgt = TGT_OFF;
            end
            if (today && s <= now && e < now) win_tgt = TGT_ON;
        end
    end

    assign os_stop = {1'b0, i_cfg.start_second} + (SEC_W+1)'(i_cfg.one_shot_window);

    // mode select; repeat is on while the remainder is below the duration
    always_comb begin
        unique case (i_cfg.mode)
            MODE_WINDOW: begin
                o_target = win_tgt;
            end
            MODE_ONE_SHOT: begin
                o_target = (today && i_cfg.start_second <= i_now
                            && os_stop >= {1'b0, i_now}) ? TGT_ON : TGT_OFF;
            end
            MODE_REPEAT: begin
                if (i_cfg.repeat_seconds == '0) begin
                    o_target = TGT_OFF;
                end else begin
                    o_target = (today && (!i_diff_neg || i_rem == '0)
                                && i_cfg.duration_seconds > i_rem) ? TGT_ON : TGT_OFF;
                end
            end
            default: begin
                o_target = TGT_NONE;
            end
        endcase
    end

endmodule

[hw/rtl/wsch_chk.sv]
// port-level checker for the weekly time window scheduler, with its bind
// depends on wsch_pkg and the weekly_time_window_scheduler top level
module wsch_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [wsch_pkg::OUT_TW-1:0] m_axis_tdata
);
    import wsch_pkg::*;

    // a pending result beat is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat dropped or changed while stalled");

    // a rise event reports the active level, a fall event the inactive one
    a_ev_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] != EV_RISE || m_axis_tdata[0])
                       && (m_axis_tdata[2:1] != EV_FALL || !m_axis_tdata[0]))
        else $error("event code disagrees with level");

    // event code never takes the unused value
    a_ev_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] == EV_NONE || m_axis_tdata[2:1] == EV_RISE
                           || m_axis_tdata[2:1] == EV_FALL))
        else $error("invalid event code");

    // the block is busy right after taking a tick
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("tick input ready while a tick is in work");

    // no result beat right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat after reset");

endmodule

bind weekly_time_window_scheduler wsch_chk u_wsch_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
